// ===== hw/rtl/tlb_page_table_translator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the address translator
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define TLBPT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("translator assertion failed");

// next-cycle implication
`define TLBPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("translator assertion failed");

`endif

// ===== hw/rtl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Address translator package
// Shared constants, item and result types, lookup kinds and helpers.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	localparam int DEF_TLB_ENTRIES = 16;
	localparam int DEF_FRAME_COUNT = 128;
	localparam int ADDR_W          = 16;
	localparam int OFFSET_BITS     = 8;
	localparam int PAGE_W          = ADDR_W - OFFSET_BITS;
	localparam int PAGE_COUNT      = 1 << PAGE_W;
	localparam int FRAME_OUT_W     = 7;
	localparam int PHYS_W          = 15;
	localparam int CNT_W           = 32;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		KIND_TLB   = 2'd0,
		KIND_PT    = 2'd1,
		KIND_FAULT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [PAGE_W-1:0]      page;
		logic [OFFSET_BITS-1:0] offset;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [PHYS_W-1:0]      phys;
		logic [FRAME_OUT_W-1:0] frame;
		logic [PAGE_W-1:0]      page;
		logic [OFFSET_BITS-1:0] offset;
		kind_t                  kind;
		logic [CNT_W-1:0]       hits;
		logic [CNT_W-1:0]       faults;
		logic [CNT_W-1:0]       xlats;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ===== hw/rtl/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// Address translator with a TLB, a page table and frame allocation.
// Input channel: virt_addr with in_valid / in_stall; the upper byte is
// the page, the lower byte the offset. Output channel: one result item per
// input with out_valid / out_stall, carrying the physical address, frame,
// page, offset, lookup kind and three saturating running counters.
// cfg_we / cfg_wdata write the replacement policy (0 FIFO, 1 LRU); write it
// only while no item is in flight.
// A TLB hit, page table hit or fault that needs no eviction of an in-use
// frame goes from lookup to commit; a FIFO eviction adds an evict step; an
// LRU eviction first scans the last-use memory one entry per cycle, then
// reads the chosen frame's owner and evicts before the commit.
// The single lookup and commit sequencer handles one item at a time.
// A two-entry queue holds accepted items while the back end works; a result
// register lets one finished item wait while the next is processed.
// Reset clears the TLB, frame and page valid bits, counters and the policy.
// A stalled result holds; the back end then waits before its commit step.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
	parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
	parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] virt_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] physical_address,
	output logic [6:0]  frame_number,
	output logic [7:0]  page_index,
	output logic [7:0]  page_offset,
	output logic [1:0]  lookup_kind,
	output logic [31:0] tlb_hit_count,
	output logic [31:0] fault_count,
	output logic [31:0] translated_count
);
	import tlbpt_pkg::*;

	`include "tlb_page_table_translator_defines.svh"

	logic    policy_q;
	q_head_t head;
	logic    pop;
	res_t    res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			policy_q <= 1'b0;
		else if (cfg_we)
			policy_q <= cfg_wdata;
	end

	tlbpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.virt_addr (virt_addr),
		.head      (head),
		.pop       (pop)
	);

	tlbpt_back #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.FRAME_COUNT (FRAME_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign physical_address = res.phys;
	assign frame_number     = res.frame;
	assign page_index       = res.page;
	assign page_offset      = res.offset;
	assign lookup_kind      = res.kind;
	assign tlb_hit_count    = res.hits;
	assign fault_count      = res.faults;
	assign translated_count = res.xlats;

	`TLBPT_ASSERT_IMPL(a_fault_counted, out_valid && lookup_kind == KIND_FAULT, fault_count != '0)
	`TLBPT_ASSERT_IMPL(a_hit_counted, out_valid && lookup_kind == KIND_TLB, tlb_hit_count != '0)
	`TLBPT_ASSERT_NEXT(a_pop_has_item, pop, !(in_stall && $past(!head.valid)))

endmodule

// ===== hw/rtl/tlbpt_front.sv =====
// ----------------------------------------------------------------------------
// Translator front end
// Accepts addresses, splits them into page and offset, queues the items.
// ----------------------------------------------------------------------------
module tlbpt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [tlbpt_pkg::ADDR_W-1:0] virt_addr,
	output tlbpt_pkg::q_head_t        head,
	input  logic                      pop
);
	import tlbpt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            q_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             push;
	logic             do_pop;

	assign in_stall = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q].page   <= virt_addr[ADDR_W-1:OFFSET_BITS];
			q_q[wr_ptr_q].offset <= virt_addr[OFFSET_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tlbpt_back.sv =====
// ----------------------------------------------------------------------------
// Translator back end
// TLB and page table lookup, frame allocation, LRU scan and result register.
// ----------------------------------------------------------------------------
module tlbpt_back #(
	parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
	parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               policy,
	input  tlbpt_pkg::q_head_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output tlbpt_pkg::res_t    res
);
	import tlbpt_pkg::*;

	localparam int TW = $clog2(TLB_ENTRIES);
	localparam int FW = $clog2(FRAME_COUNT);
	localparam int CW = FW + 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOK   = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_OWN    = 6'b001000,
		ST_EVICT  = 6'b010000,
		ST_COMMIT = 6'b100000
	} state_t;

	state_t state_q;

	logic [PAGE_W-1:0] tlb_page_q  [TLB_ENTRIES];
	logic [FW-1:0]     tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TW-1:0]     tlb_slot_q;

	logic [PAGE_W-1:0] owner_mem    [FRAME_COUNT];
	logic [CNT_W-1:0]  last_use_mem [FRAME_COUNT];
	logic [FW-1:0]     pmap_mem     [PAGE_COUNT];
	logic [FRAME_COUNT-1:0] in_use_q;
	logic [PAGE_COUNT-1:0]  pmap_valid_q;
	logic [FW-1:0]     next_frame_q;

	logic [CNT_W-1:0]  use_clock_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [CNT_W-1:0]  fault_cnt_q;
	logic [CNT_W-1:0]  xlat_cnt_q;

	logic [PAGE_W-1:0]      cur_page_q;
	logic [OFFSET_BITS-1:0] cur_off_q;
	logic [FW-1:0]          frame_q;
	kind_t                  kind_q;

	logic [FW-1:0]     pmap_rd_q;
	logic [PAGE_W-1:0] owner_rd_q;
	logic [CNT_W-1:0]  lu_rd_q;
	logic [FW-1:0]     owner_raddr;

	logic [CW-1:0]     scan_rd_q;
	logic              lu_vld_s1;
	logic [FW-1:0]     lu_idx_s1;
	logic [CNT_W-1:0]  best_q;
	logic [FW-1:0]     best_idx_q;
	logic              best_vld_q;

	logic              out_valid_q;
	res_t              res_q;

	logic              tlb_hit;
	logic [FW-1:0]     tlb_hframe;
	logic              commit_go;
	logic [CNT_W-1:0]  uc_nxt;
	logic [CNT_W-1:0]  hit_nxt;
	logic [CNT_W-1:0]  fault_nxt;
	logic [CNT_W-1:0]  xlat_nxt;
	logic [FW+7:0]     frame_ext;
	logic [FW-1:0]     nf_wrap;

	// lowest matching slot wins
	always_comb begin
		tlb_hit    = 1'b0;
		tlb_hframe = '0;
		for (int i = TLB_ENTRIES-1; i >= 0; i--) begin
			if (tlb_valid_q[i] && tlb_page_q[i] == cur_page_q) begin
				tlb_hit    = 1'b1;
				tlb_hframe = tlb_frame_q[i];
			end
		end
	end

	assign pop         = (state_q == ST_IDLE) && head.valid;
	assign commit_go   = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	assign owner_raddr = (state_q == ST_OWN) ? best_idx_q : next_frame_q;
	assign nf_wrap     = (next_frame_q == FW'(FRAME_COUNT-1)) ? '0 : next_frame_q + 1'b1;

	assign uc_nxt    = sat_inc(use_clock_q);
	assign xlat_nxt  = sat_inc(xlat_cnt_q);
	assign hit_nxt   = (kind_q == KIND_TLB) ? sat_inc(hit_cnt_q) : hit_cnt_q;
	assign fault_nxt = (kind_q == KIND_FAULT) ? sat_inc(fault_cnt_q) : fault_cnt_q;
	assign frame_ext = {8'd0, frame_q};

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// memories: one write and registered reads
	always_ff @(posedge clk) begin
		pmap_rd_q  <= pmap_mem[head.item.page];
		owner_rd_q <= owner_mem[owner_raddr];
		lu_rd_q    <= last_use_mem[scan_rd_q[FW-1:0]];
		if (commit_go) begin
			last_use_mem[frame_q] <= uc_nxt;
			if (kind_q == KIND_FAULT) begin
				owner_mem[frame_q]   <= cur_page_q;
				pmap_mem[cur_page_q] <= frame_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_page_q <= head.item.page;
			cur_off_q  <= head.item.offset;
		end
		if (commit_go) begin
			res_q.phys   <= {frame_ext[FRAME_OUT_W-1:0], cur_off_q};
			res_q.frame  <= frame_ext[FRAME_OUT_W-1:0];
			res_q.page   <= cur_page_q;
			res_q.offset <= cur_off_q;
			res_q.kind   <= kind_q;
			res_q.hits   <= hit_nxt;
			res_q.faults <= fault_nxt;
			res_q.xlats  <= xlat_nxt;
		end
		if (commit_go && kind_q != KIND_TLB) begin
			tlb_page_q[tlb_slot_q]  <= cur_page_q;
			tlb_frame_q[tlb_slot_q] <= frame_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tlb_valid_q  <= '0;
			tlb_slot_q   <= '0;
			in_use_q     <= '0;
			pmap_valid_q <= '0;
			next_frame_q <= '0;
			use_clock_q  <= '0;
			hit_cnt_q    <= '0;
			fault_cnt_q  <= '0;
			xlat_cnt_q   <= '0;
			frame_q      <= '0;
			kind_q       <= KIND_TLB;
			scan_rd_q    <= '0;
			lu_vld_s1    <= 1'b0;
			lu_idx_s1    <= '0;
			best_q       <= '0;
			best_idx_q   <= '0;
			best_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (commit_go)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (head.valid)
						state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (tlb_hit) begin
						frame_q <= tlb_hframe;
						kind_q  <= KIND_TLB;
						state_q <= ST_COMMIT;
					end else if (pmap_valid_q[cur_page_q]) begin
						frame_q <= pmap_rd_q;
						kind_q  <= KIND_PT;
						state_q <= ST_COMMIT;
					end else begin
						kind_q <= KIND_FAULT;
						if (!in_use_q[next_frame_q] || !policy) begin
							frame_q      <= next_frame_q;
							next_frame_q <= nf_wrap;
							state_q      <= in_use_q[next_frame_q] ? ST_EVICT : ST_COMMIT;
						end else begin
							scan_rd_q  <= '0;
							lu_vld_s1  <= 1'b0;
							best_vld_q <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one last-use read issued and one compared per cycle
					if (scan_rd_q < CW'(FRAME_COUNT))
						scan_rd_q <= scan_rd_q + 1'b1;
					lu_vld_s1 <= (scan_rd_q < CW'(FRAME_COUNT));
					lu_idx_s1 <= scan_rd_q[FW-1:0];
					if (lu_vld_s1) begin
						if (!best_vld_q || lu_rd_q < best_q) begin
							best_q     <= lu_rd_q;
							best_idx_q <= lu_idx_s1;
							best_vld_q <= 1'b1;
						end
						if (lu_idx_s1 == FW'(FRAME_COUNT-1))
							state_q <= ST_OWN;
					end
				end
				ST_OWN: begin
					frame_q <= best_idx_q;
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					// drop the old page's mapping and stale TLB entries
					pmap_valid_q[owner_rd_q] <= 1'b0;
					for (int i = 0; i < TLB_ENTRIES; i++) begin
						if (tlb_frame_q[i] == frame_q)
							tlb_valid_q[i] <= 1'b0;
					end
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_go) begin
						use_clock_q <= uc_nxt;
						xlat_cnt_q  <= xlat_nxt;
						hit_cnt_q   <= hit_nxt;
						fault_cnt_q <= fault_nxt;
						if (kind_q != KIND_TLB) begin
							tlb_valid_q[tlb_slot_q] <= 1'b1;
							tlb_slot_q <= (tlb_slot_q == TW'(TLB_ENTRIES-1)) ?
								'0 : tlb_slot_q + 1'b1;
						end
						if (kind_q == KIND_FAULT) begin
							in_use_q[frame_q]        <= 1'b1;
							pmap_valid_q[cur_page_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
